// ===== hdl/srsw_pkg.sv =====
`default_nettype none

package srsw_pkg;

   // Width of the window size register and of the entry counters.
   localparam int CSR_W = 4;

   // Window size after reset, before any limit is applied.
   localparam logic [CSR_W-1:0] SIZE_RESET = 4'd8;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STATUS,
      ST_SLIDE,
      ST_SCAN,
      ST_FINAL
   } state_type;

   // Kind of result loaded into the output register.
   typedef enum logic [1:0] {
      PUSH_NONE,
      PUSH_STATUS,
      PUSH_PEND,
      PUSH_FINAL
   } push_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     accept;
      logic     slide_step;
      logic     scan_start;
      logic     scan_adv;
      logic     pend_load;
      push_type push;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic go_slide;
      logic slide_more;
      logic scan_done;
      logic scan_unmarked;
      logic pend_valid;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== hdl/srsw_ctrl.sv =====
`default_nettype none

module srsw_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire srsw_pkg::sts_type sts,
   output srsw_pkg::cmd_type     cmd
);
   import srsw_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.push       = PUSH_NONE;
      req_ready      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sts.go_slide ? ST_SLIDE : ST_STATUS;
            end
         end
         ST_STATUS: begin
            if (sts.out_free) begin
               cmd.push = PUSH_STATUS;
               state_in = ST_IDLE;
            end
         end
         ST_SLIDE: begin
            // Walk the base past the run of acked entries.
            if (sts.slide_more) begin
               cmd.slide_step = 1'b1;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // One found entry is held back so the final one can carry last.
            priority if (sts.scan_done) begin
               state_in = ST_FINAL;
            end else if (!sts.scan_unmarked) begin
               cmd.scan_adv = 1'b1;
            end else if (!sts.pend_valid) begin
               cmd.pend_load = 1'b1;
               cmd.scan_adv  = 1'b1;
            end else if (sts.out_free) begin
               cmd.push      = PUSH_PEND;
               cmd.pend_load = 1'b1;
               cmd.scan_adv  = 1'b1;
            end else begin
               // Wait here until the output register frees up.
               cmd.scan_adv = 1'b0;
            end
         end
         ST_FINAL: begin
            if (sts.out_free) begin
               cmd.push = PUSH_FINAL;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/srsw_dp.sv =====
`default_nettype none

module srsw_dp #(
   parameter int SEQ_SPACE  = 16,
   parameter int MAX_WINDOW = 8,
   parameter int SEQ_W      = $clog2(SEQ_SPACE)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   input  wire logic [srsw_pkg::CSR_W-1:0]    csr_window_size,
   input  wire logic [SEQ_W-1:0]              req_ack_seq,
   input  wire srsw_pkg::cmd_type             cmd,
   output srsw_pkg::sts_type                  sts,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_ack_in_window,
   output logic                               rsp_slid,
   output logic [SEQ_W-1:0]                   rsp_new_base,
   output logic                               rsp_resend_valid,
   output logic [SEQ_W-1:0]                   rsp_resend_seq,
   output logic                               rsp_last
);
   import srsw_pkg::*;

   localparam int LIMIT = (MAX_WINDOW < SEQ_SPACE) ? MAX_WINDOW : SEQ_SPACE;
   localparam int CMP_W = (SEQ_W + 1 > CSR_W) ? SEQ_W + 1 : CSR_W;
   localparam logic [SEQ_W:0]   SPACE_L = (SEQ_W + 1)'(SEQ_SPACE);
   localparam logic [SEQ_W-1:0] TOP_SEQ = SEQ_W'(SEQ_SPACE - 1);

   // Window size with zero raised to one and large values saturated.
   function automatic logic [CSR_W-1:0] eff_size(input logic [CSR_W-1:0] raw);
      logic [CSR_W-1:0] s;
      s = (raw == '0) ? CSR_W'(1) : raw;
      if (int'(s) > LIMIT) s = CSR_W'(LIMIT);
      return s;
   endfunction

   // Next sequence number, wrapping at the top of the space.
   function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] p);
      return (p == TOP_SEQ) ? '0 : p + 1'b1;
   endfunction

   logic [CSR_W-1:0]     size_ff;
   logic [SEQ_W-1:0]     base_ff;
   logic [SEQ_W-1:0]     ptr_ff;
   logic [CSR_W-1:0]     cnt_ff;
   logic [SEQ_SPACE-1:0] mark_ff;
   logic                 inw_ff;
   logic                 pend_valid_ff;
   logic [SEQ_W-1:0]     pend_ff;
   logic                 rsp_valid_ff;
   logic                 inw_out_ff;
   logic                 slid_ff;
   logic [SEQ_W-1:0]     new_base_ff;
   logic                 rv_ff;
   logic [SEQ_W-1:0]     rs_ff;
   logic                 last_ff;

   logic [SEQ_W:0]       ack_ext;
   logic [SEQ_W-1:0]     ack_red;
   logic [SEQ_W:0]       ack_red_ext;
   logic [SEQ_W:0]       base_ext;
   logic [SEQ_W:0]       ack_offset;
   logic                 inw;
   logic                 cur_mark;

   // Ack reduced into the sequence space and its distance from the base.
   always_comb begin
      ack_ext     = {1'b0, req_ack_seq};
      ack_red     = (ack_ext >= SPACE_L) ? SEQ_W'(ack_ext - SPACE_L) : req_ack_seq;
      ack_red_ext = {1'b0, ack_red};
      base_ext    = {1'b0, base_ff};
      ack_offset  = (ack_red_ext >= base_ext) ? ack_red_ext - base_ext
                                              : ack_red_ext + SPACE_L - base_ext;
      inw         = CMP_W'(ack_offset) < CMP_W'(size_ff);
   end

   assign cur_mark = mark_ff[ptr_ff];

   // Status toward the controller.
   always_comb begin
      sts.go_slide      = inw && (ack_red == base_ff);
      sts.slide_more    = (cnt_ff < size_ff) && cur_mark;
      sts.scan_done     = (cnt_ff == size_ff);
      sts.scan_unmarked = !cur_mark;
      sts.pend_valid    = pend_valid_ff;
      sts.out_free      = !rsp_valid_ff || rsp_ready;
   end

   // Window size register.
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= eff_size(SIZE_RESET);
      end else if (csr_valid) begin
         size_ff <= eff_size(csr_window_size);
      end
   end

   // Window base, walking pointer, entry counter and acked marks.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         ptr_ff        <= '0;
         cnt_ff        <= '0;
         mark_ff       <= '0;
         inw_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            inw_ff <= inw;
            ptr_ff <= base_ff;
            cnt_ff <= '0;
            if (inw) begin
               mark_ff[ack_red] <= 1'b1;
            end
         end
         if (cmd.slide_step) begin
            mark_ff[ptr_ff] <= 1'b0;
            base_ff         <= seq_inc(base_ff);
            ptr_ff          <= seq_inc(ptr_ff);
            cnt_ff          <= cnt_ff + 1'b1;
         end
         if (cmd.scan_start) begin
            cnt_ff        <= '0;
            pend_valid_ff <= 1'b0;
         end
         if (cmd.scan_adv) begin
            ptr_ff <= seq_inc(ptr_ff);
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.pend_load) begin
            pend_valid_ff <= 1'b1;
         end
      end
   end

   // Held-back resend number.
   always_ff @(posedge clock) begin
      if (cmd.pend_load) begin
         pend_ff <= ptr_ff;
      end
   end

   // Output register valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push != PUSH_NONE) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      unique case (cmd.push)
         PUSH_STATUS: begin
            inw_out_ff  <= inw_ff;
            slid_ff     <= 1'b0;
            new_base_ff <= base_ff;
            rv_ff       <= 1'b0;
            rs_ff       <= '0;
            last_ff     <= 1'b1;
         end
         PUSH_PEND: begin
            inw_out_ff  <= 1'b1;
            slid_ff     <= 1'b1;
            new_base_ff <= base_ff;
            rv_ff       <= 1'b1;
            rs_ff       <= pend_ff;
            last_ff     <= 1'b0;
         end
         PUSH_FINAL: begin
            inw_out_ff  <= 1'b1;
            slid_ff     <= 1'b1;
            new_base_ff <= base_ff;
            rv_ff       <= pend_valid_ff;
            rs_ff       <= pend_valid_ff ? pend_ff : '0;
            last_ff     <= 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ack_in_window = inw_out_ff;
   assign rsp_slid          = slid_ff;
   assign rsp_new_base      = new_base_ff;
   assign rsp_resend_valid  = rv_ff;
   assign rsp_resend_seq    = rs_ff;
   assign rsp_last          = last_ff;

endmodule

`default_nettype wire

// ===== hdl/selective_repeat_sender_window_unit.sv =====
`default_nettype none

// Sender window of selective-repeat ARQ. Each req beat carries one received
// ack number; an ack inside the window marks its entry, and an ack equal to
// the window base slides the base past the run of acked entries and then
// lists every unacked number of the new window as rsp beats, the final one
// with rsp_last set. Any other ack gives one status beat. The user must write
// the window size through the csr channel only while the block is idle; the
// block itself does not enforce this. A non-sliding ack passes through the
// status state, which waits for a free output register, before the next req
// beat is taken. With W window entries a sliding ack walks the acked marks
// one entry per cycle unless the rsp side stalls, sliding one to W steps and
// then scanning W steps for resends. No clearing pass is needed after reset.
module selective_repeat_sender_window_unit #(
   parameter int SEQ_SPACE  = 16,
   parameter int MAX_WINDOW = 8,
   parameter int SEQ_W      = $clog2(SEQ_SPACE)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [srsw_pkg::CSR_W-1:0]  csr_window_size,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [SEQ_W-1:0]            req_ack_seq,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_ack_in_window,
   output logic                             rsp_slid,
   output logic [SEQ_W-1:0]                 rsp_new_base,
   output logic                             rsp_resend_valid,
   output logic [SEQ_W-1:0]                 rsp_resend_seq,
   output logic                             rsp_last
);
   import srsw_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   // Sequencer.
   srsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Window state and output register.
   srsw_dp #(
      .SEQ_SPACE  (SEQ_SPACE),
      .MAX_WINDOW (MAX_WINDOW),
      .SEQ_W      (SEQ_W)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_window_size   (csr_window_size),
      .req_ack_seq       (req_ack_seq),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_ack_in_window (rsp_ack_in_window),
      .rsp_slid          (rsp_slid),
      .rsp_new_base      (rsp_new_base),
      .rsp_resend_valid  (rsp_resend_valid),
      .rsp_resend_seq    (rsp_resend_seq),
      .rsp_last          (rsp_last)
   );

endmodule

`default_nettype wire

// ===== hdl/srsw_checker.sv =====
`default_nettype none

module srsw_checker #(
   parameter int SEQ_W = 4
) (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic                        rsp_ack_in_window,
   input wire logic                        rsp_slid,
   input wire logic [SEQ_W-1:0]            rsp_new_base,
   input wire logic                        rsp_resend_valid,
   input wire logic [SEQ_W-1:0]            rsp_resend_seq,
   input wire logic                        rsp_last
);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_base)
         && $stable(rsp_resend_seq) && $stable(rsp_last) && $stable(rsp_slid)
         && $stable(rsp_ack_in_window) && $stable(rsp_resend_valid))
      else $error("result beat changed while stalled");

   // A beat without a slide is a lone status beat.
   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_slid |-> rsp_last && !rsp_resend_valid)
      else $error("status beat malformed");

   // A slide only follows an ack inside the window.
   a_slide_in_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_slid |-> rsp_ack_in_window)
      else $error("slide without an ack in the window");

   // An accepted ack keeps the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second ack taken back to back");

endmodule

bind selective_repeat_sender_window_unit srsw_checker #(.SEQ_W(SEQ_W)) u_srsw_checker (.*);

`default_nettype wire
